// ===== rtl/spot_pkg.sv =====
// ============================================================================
// spot_pkg: shared types and constants of the shape pair overlap test
// Word layouts, pipeline stage records, mode codes and derived widths.
// ============================================================================
package spot_pkg;

    // Width of a center coordinate (two's complement).
    localparam int COORD_BITS = 16;
    // Width of a half extent; the half width doubles as a circle radius.
    localparam int HALF_BITS  = 15;
    // A summed radius of two circles needs one more bit.
    localparam int RAD_BITS   = HALF_BITS + 1;
    // Width of a box edge, center plus or minus a half extent.
    localparam int EXT_BITS   = ((COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS) + 1;
    // Width of a point-to-edge difference.
    localparam int DIFF_BITS  = EXT_BITS + 1;
    // Distance components are clamped here before squaring.
    localparam int DIST_CLAMP = 32'h0002_0000;
    localparam int MAG_BITS   = $clog2(DIST_CLAMP) + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int RSQ_BITS   = 2 * RAD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;

    typedef enum logic [3:0] {
        MODE_CC = 4'd0,
        MODE_CP = 4'd1,
        MODE_RR = 4'd2,
        MODE_RP = 4'd3,
        MODE_PC = 4'd4,
        MODE_PR = 4'd5,
        MODE_CR = 4'd6,
        MODE_RC = 4'd7
    } t_mode;

    // Which final rule decides the hit.
    typedef enum logic [1:0] {
        K_CIRC,
        K_BOX,
        K_RCIRC,
        K_NONE
    } t_kind;

    typedef struct packed {
        logic [3:0]                   mode;
        logic signed [COORD_BITS-1:0] a_center_x;
        logic signed [COORD_BITS-1:0] a_center_y;
        logic [HALF_BITS-1:0]         a_half_width;
        logic [HALF_BITS-1:0]         a_half_height;
        logic signed [COORD_BITS-1:0] b_center_x;
        logic signed [COORD_BITS-1:0] b_center_y;
        logic [HALF_BITS-1:0]         b_half_width;
        logic [HALF_BITS-1:0]         b_half_height;
    } t_in_word;

    typedef struct packed {
        logic hit;
        logic unsupported;
    } t_out_word;

    // After normalization: rect edges, other-shape edges, other-shape center.
    typedef struct packed {
        t_kind                      kind;
        logic signed [EXT_BITS-1:0] r_left;
        logic signed [EXT_BITS-1:0] r_right;
        logic signed [EXT_BITS-1:0] r_top;
        logic signed [EXT_BITS-1:0] r_bottom;
        logic signed [EXT_BITS-1:0] s_left;
        logic signed [EXT_BITS-1:0] s_right;
        logic signed [EXT_BITS-1:0] s_top;
        logic signed [EXT_BITS-1:0] s_bottom;
        logic signed [EXT_BITS-1:0] px;
        logic signed [EXT_BITS-1:0] py;
        logic [RAD_BITS-1:0]        rad;
    } t_s1;

    typedef struct packed {
        t_kind               kind;
        logic                box_hit;
        logic                band;
        logic [MAG_BITS-1:0] mag_x;
        logic [MAG_BITS-1:0] mag_y;
        logic [RAD_BITS-1:0] rad;
    } t_s2;

    typedef struct packed {
        t_kind               kind;
        logic                box_hit;
        logic                band;
        logic [SQ_BITS-1:0]  sq_x;
        logic [SQ_BITS-1:0]  sq_y;
        logic [RSQ_BITS-1:0] rad_sq;
    } t_s3;

endpackage

// ===== rtl/spot_in_if.sv =====
// ============================================================================
// spot_in_if: input channel of the shape pair overlap test
// Valid/ready channel carrying one shape pair word.
// ============================================================================
interface spot_in_if;
    logic               valid;
    logic               ready;
    spot_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spot_out_if.sv =====
// ============================================================================
// spot_out_if: result channel of the shape pair overlap test
// Valid/ready channel carrying one hit word.
// ============================================================================
interface spot_out_if;
    logic                valid;
    logic                ready;
    spot_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spot_norm.sv =====
// ============================================================================
// spot_norm: pipeline stage 1, pair normalization
// Maps each t_mode code onto a rect and a second shape and forms their box edges; other codes get K_NONE.
// ============================================================================
module spot_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_en,
    input  spot_pkg::t_in_word i_word,
    output logic               o_valid,
    output spot_pkg::t_s1      o_s1
);

    logic                                   r_valid;
    spot_pkg::t_s1                          r_s1;
    spot_pkg::t_s1                          n_s1;

    logic signed [spot_pkg::COORD_BITS-1:0] rcx, rcy, scx, scy;
    logic [spot_pkg::HALF_BITS-1:0]         rhw, rhh, shw, shh;
    logic signed [spot_pkg::EXT_BITS-1:0]   rcx_e, rcy_e, scx_e, scy_e;
    logic signed [spot_pkg::EXT_BITS-1:0]   rhw_e, rhh_e, shw_e, shh_e;

    always_comb begin
        rcx       = i_word.a_center_x;
        rcy       = i_word.a_center_y;
        rhw       = i_word.a_half_width;
        rhh       = i_word.a_half_height;
        scx       = i_word.b_center_x;
        scy       = i_word.b_center_y;
        shw       = i_word.b_half_width;
        shh       = i_word.b_half_height;
        n_s1.kind = spot_pkg::K_NONE;
        n_s1.rad  = '0;
        // For circle pairs the rect side collapses to A's center, so its
        // left/top edges give the point that the distance is taken to.
        unique case (i_word.mode)
            spot_pkg::MODE_CC: begin
                n_s1.kind = spot_pkg::K_CIRC;
                n_s1.rad  = spot_pkg::RAD_BITS'(i_word.a_half_width)
                          + spot_pkg::RAD_BITS'(i_word.b_half_width);
                rhw       = '0;
                rhh       = '0;
            end
            spot_pkg::MODE_CP: begin
                n_s1.kind = spot_pkg::K_CIRC;
                n_s1.rad  = spot_pkg::RAD_BITS'(i_word.a_half_width);
                rhw       = '0;
                rhh       = '0;
            end
            spot_pkg::MODE_PC: begin
                n_s1.kind = spot_pkg::K_CIRC;
                n_s1.rad  = spot_pkg::RAD_BITS'(i_word.b_half_width);
                rhw       = '0;
                rhh       = '0;
            end
            spot_pkg::MODE_RR: begin
                n_s1.kind = spot_pkg::K_BOX;
            end
            spot_pkg::MODE_RP: begin
                n_s1.kind = spot_pkg::K_BOX;
                shw       = '0;
                shh       = '0;
            end
            spot_pkg::MODE_PR: begin
                n_s1.kind = spot_pkg::K_BOX;
                rhw       = '0;
                rhh       = '0;
            end
            spot_pkg::MODE_CR: begin
                n_s1.kind = spot_pkg::K_RCIRC;
                n_s1.rad  = spot_pkg::RAD_BITS'(i_word.a_half_width);
                rcx       = i_word.b_center_x;
                rcy       = i_word.b_center_y;
                rhw       = i_word.b_half_width;
                rhh       = i_word.b_half_height;
                scx       = i_word.a_center_x;
                scy       = i_word.a_center_y;
                shw       = i_word.a_half_width;
                shh       = i_word.a_half_width;
            end
            spot_pkg::MODE_RC: begin
                n_s1.kind = spot_pkg::K_RCIRC;
                n_s1.rad  = spot_pkg::RAD_BITS'(i_word.b_half_width);
                shh       = i_word.b_half_width;
            end
            default: begin
                n_s1.kind = spot_pkg::K_NONE;
            end
        endcase

        rcx_e = spot_pkg::EXT_BITS'(rcx);
        rcy_e = spot_pkg::EXT_BITS'(rcy);
        scx_e = spot_pkg::EXT_BITS'(scx);
        scy_e = spot_pkg::EXT_BITS'(scy);
        rhw_e = spot_pkg::EXT_BITS'(rhw);
        rhh_e = spot_pkg::EXT_BITS'(rhh);
        shw_e = spot_pkg::EXT_BITS'(shw);
        shh_e = spot_pkg::EXT_BITS'(shh);

        n_s1.r_left   = rcx_e - rhw_e;
        n_s1.r_right  = rcx_e + rhw_e;
        n_s1.r_top    = rcy_e - rhh_e;
        n_s1.r_bottom = rcy_e + rhh_e;
        n_s1.s_left   = scx_e - shw_e;
        n_s1.s_right  = scx_e + shw_e;
        n_s1.s_top    = scy_e - shh_e;
        n_s1.s_bottom = scy_e + shh_e;
        n_s1.px       = scx_e;
        n_s1.py       = scy_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ===== rtl/spot_geom.sv =====
// ============================================================================
// spot_geom: pipeline stage 2, edge compares and distance components
// Box overlap, band test, corner choice and clamped distance magnitudes.
// ============================================================================
module spot_geom (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_en,
    input  spot_pkg::t_s1 i_s1,
    output logic          o_valid,
    output spot_pkg::t_s2 o_s2
);

    logic                                  r_valid;
    spot_pkg::t_s2                         r_s2;
    spot_pkg::t_s2                         n_s2;

    logic signed [spot_pkg::EXT_BITS-1:0]  tx, ty;
    logic signed [spot_pkg::DIFF_BITS-1:0] dx, dy;
    logic [spot_pkg::DIFF_BITS-1:0]        ax, ay;

    always_comb begin
        n_s2.kind    = i_s1.kind;
        n_s2.rad     = i_s1.rad;
        // Touching edges do not count as overlap.
        n_s2.box_hit = !((i_s1.r_bottom <= i_s1.s_top) || (i_s1.r_top >= i_s1.s_bottom) ||
                         (i_s1.r_left >= i_s1.s_right) || (i_s1.r_right <= i_s1.s_left));
        n_s2.band    = ((i_s1.r_left <= i_s1.px) && (i_s1.px < i_s1.r_right)) ||
                       ((i_s1.r_top <= i_s1.py) && (i_s1.py < i_s1.r_bottom));

        // Outside both bands the center sits in exactly one corner quadrant.
        if (i_s1.kind == spot_pkg::K_CIRC) begin
            tx = i_s1.r_left;
            ty = i_s1.r_top;
        end else begin
            tx = (i_s1.px >= i_s1.r_right) ? i_s1.r_right : i_s1.r_left;
            ty = (i_s1.py <= i_s1.r_top) ? i_s1.r_top : i_s1.r_bottom;
        end

        dx = spot_pkg::DIFF_BITS'(i_s1.px) - spot_pkg::DIFF_BITS'(tx);
        dy = spot_pkg::DIFF_BITS'(i_s1.py) - spot_pkg::DIFF_BITS'(ty);
        ax = dx[spot_pkg::DIFF_BITS-1] ? spot_pkg::DIFF_BITS'(-dx) : spot_pkg::DIFF_BITS'(dx);
        ay = dy[spot_pkg::DIFF_BITS-1] ? spot_pkg::DIFF_BITS'(-dy) : spot_pkg::DIFF_BITS'(dy);

        n_s2.mag_x = (ax > spot_pkg::DIFF_BITS'(spot_pkg::DIST_CLAMP))
                   ? spot_pkg::MAG_BITS'(spot_pkg::DIST_CLAMP) : spot_pkg::MAG_BITS'(ax);
        n_s2.mag_y = (ay > spot_pkg::DIFF_BITS'(spot_pkg::DIST_CLAMP))
                   ? spot_pkg::MAG_BITS'(spot_pkg::DIST_CLAMP) : spot_pkg::MAG_BITS'(ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// ===== rtl/spot_sq.sv =====
// ============================================================================
// spot_sq: pipeline stage 3, squaring
// Squares both distance components and the radius in parallel multipliers.
// ============================================================================
module spot_sq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_en,
    input  spot_pkg::t_s2 i_s2,
    output logic          o_valid,
    output spot_pkg::t_s3 o_s3
);

    logic          r_valid;
    spot_pkg::t_s3 r_s3;
    spot_pkg::t_s3 n_s3;

    always_comb begin
        n_s3.kind    = i_s2.kind;
        n_s3.box_hit = i_s2.box_hit;
        n_s3.band    = i_s2.band;
        n_s3.sq_x    = spot_pkg::SQ_BITS'(i_s2.mag_x) * spot_pkg::SQ_BITS'(i_s2.mag_x);
        n_s3.sq_y    = spot_pkg::SQ_BITS'(i_s2.mag_y) * spot_pkg::SQ_BITS'(i_s2.mag_y);
        n_s3.rad_sq  = spot_pkg::RSQ_BITS'(i_s2.rad) * spot_pkg::RSQ_BITS'(i_s2.rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_valid;
    assign o_s3    = r_s3;

endmodule

// ===== rtl/shape_pair_overlap_test_top.sv =====
// ============================================================================
// shape_pair_overlap_test_top: 2-D shape pair overlap test
// Four-stage pipeline: normalize, compare edges, square, sum and decide.
// ============================================================================
//  Port    | Dir | Word                           | Handshake
//  i_in    | in  | mode, centers and half extents | valid/ready
//  o_out   | out | hit, unsupported               | valid/ready
//
// One word enters per cycle while no stall holds i_in.ready low. A word is
// loaded into the first of the four register stages at the edge that accepts
// it and moves through stages 2 and 3 into the output register, where its result is offered.
// Reset clears the stage valid bits only; no state is kept between words.
// A stalled output holds its word and back-pressure moves up stage by stage,
// so empty stages keep filling; i_in.ready drops only when all stages are full.
module shape_pair_overlap_test_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spot_in_if.sink     i_in,
    spot_out_if.source  o_out
);

    logic                                 v1, v2, v3;
    logic                                 en1, en2, en3, en4;
    spot_pkg::t_s1                        s1;
    spot_pkg::t_s2                        s2;
    spot_pkg::t_s3                        s3;

    logic                                 r_out_valid;
    spot_pkg::t_out_word                  r_out_word;
    spot_pkg::t_out_word                  n_out_word;
    logic [spot_pkg::SUM_BITS-1:0]        dist_sq;
    logic [spot_pkg::SUM_BITS-1:0]        rad_sq;

    assign en4        = !r_out_valid || o_out.ready;
    assign en3        = !v3 || en4;
    assign en2        = !v2 || en3;
    assign en1        = !v1 || en2;
    assign i_in.ready = en1;

    spot_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_en    (en1),
        .i_word  (i_in.data),
        .o_valid (v1),
        .o_s1    (s1)
    );

    spot_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_en    (en2),
        .i_s1    (s1),
        .o_valid (v2),
        .o_s2    (s2)
    );

    spot_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .i_en    (en3),
        .i_s2    (s2),
        .o_valid (v3),
        .o_s3    (s3)
    );

    always_comb begin
        dist_sq                = spot_pkg::SUM_BITS'(s3.sq_x) + spot_pkg::SUM_BITS'(s3.sq_y);
        rad_sq                 = spot_pkg::SUM_BITS'(s3.rad_sq);
        n_out_word.hit         = 1'b0;
        n_out_word.unsupported = 1'b0;
        unique case (s3.kind)
            spot_pkg::K_CIRC: begin
                n_out_word.hit = rad_sq > dist_sq;
            end
            spot_pkg::K_BOX: begin
                n_out_word.hit = s3.box_hit;
            end
            spot_pkg::K_RCIRC: begin
                // Inside a band the expanded box decides; otherwise the corner.
                n_out_word.hit = s3.band ? s3.box_hit : (dist_sq <= rad_sq);
            end
            default: begin
                n_out_word.unsupported = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en4) begin
            r_out_valid <= v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    a_unsup_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.unsupported) |-> !o_out.data.hit)
        else $error("unsupported word carries a hit");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (v1 && v2 && v3 && o_out.valid && !o_out.ready))
        else $error("input held off while the pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !v1 && !v2 && !v3))
        else $error("pipeline not empty after reset");

endmodule
